// ===== rtl/ir_remote_frame_encoder_assert.svh =====
// Assertion macros for the IR remote frame encoder.
// Included by the top level; needs no other file.
`ifndef IR_REMOTE_FRAME_ENCODER_ASSERT_SVH
`define IR_REMOTE_FRAME_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IRFE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define IRFE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/irfe_pkg.sv =====
// Shared types, constants and segment tables of the IR remote frame encoder.
// No dependencies.
package irfe_pkg;

    localparam int LEAD_W    = 17;
    localparam int TRAIL_W   = 14;
    localparam int CARRIER_W = 6;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = 6;

    typedef enum logic [1:0] {
        PROTO_NEC     = 2'd0,
        PROTO_SAMSUNG = 2'd1,
        PROTO_RC5     = 2'd2,
        PROTO_SIRC    = 2'd3
    } proto_t;

    // Frame phases, in send order.
    typedef enum logic [2:0] {
        PH_PRE   = 3'd0,
        PH_START = 3'd1,
        PH_DATA  = 3'd2,
        PH_END   = 3'd3,
        PH_GAP   = 3'd4
    } phase_t;

    localparam int NUM_PH = 5;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    typedef struct packed {
        logic               level;
        logic [LEAD_W-1:0]  lead;
        logic [TRAIL_W-1:0] trail;
    } seg_t;

    typedef struct packed {
        logic load;
        logic shift;
    } sh_ctl_t;

    localparam logic [CARRIER_W-1:0] CK_NEC  = 6'd38;
    localparam logic [CARRIER_W-1:0] CK_RC5  = 6'd36;
    localparam logic [CARRIER_W-1:0] CK_SIRC = 6'd40;

    function automatic logic [CARRIER_W-1:0] carrier_of(input proto_t p);
        logic [CARRIER_W-1:0] c;
        unique case (p)
            PROTO_RC5:  c = CK_RC5;
            PROTO_SIRC: c = CK_SIRC;
            default:    c = CK_NEC;
        endcase
        return c;
    endfunction

    // Which phases a frame contains.
    function automatic logic [NUM_PH-1:0] phase_mask(input proto_t p, input logic rep);
        logic [NUM_PH-1:0] m;
        m = '0;
        unique case (p)
            PROTO_NEC: begin
                if (rep) begin
                    m[PH_PRE] = 1'b1; m[PH_START] = 1'b1; m[PH_END] = 1'b1; m[PH_GAP] = 1'b1;
                end else begin
                    m[PH_START] = 1'b1; m[PH_DATA] = 1'b1; m[PH_END] = 1'b1;
                end
            end
            PROTO_SAMSUNG: begin
                m[PH_START] = 1'b1; m[PH_DATA] = 1'b1; m[PH_END] = 1'b1; m[PH_GAP] = 1'b1;
            end
            PROTO_RC5: begin
                m[PH_DATA] = 1'b1; m[PH_GAP] = 1'b1;
            end
            default: begin
                m[PH_START] = 1'b1; m[PH_DATA] = 1'b1; m[PH_GAP] = 1'b1;
            end
        endcase
        return m;
    endfunction

    function automatic phase_t first_phase(input logic [NUM_PH-1:0] m);
        phase_t ph;
        ph = PH_GAP;
        for (int i = NUM_PH - 1; i >= 0; i--) begin
            if (m[i]) ph = phase_t'(3'(i));
        end
        return ph;
    endfunction

    // Segment for a phase; bit only matters in the data phase.
    function automatic seg_t seg_value(input proto_t p, input logic rep,
                                       input phase_t ph, input logic b);
        seg_t s;
        s = '{level: 1'b1, lead: 17'd552, trail: 14'd543};
        unique case (ph)
            PH_PRE: s = '{level: 1'b0, lead: 17'd40000, trail: 14'd0};
            PH_START: begin
                case (p)
                    PROTO_NEC:     s = '{level: 1'b1, lead: 17'd9000,
                                         trail: rep ? 14'd2250 : 14'd4500};
                    PROTO_SAMSUNG: s = '{level: 1'b1, lead: 17'd4500, trail: 14'd4500};
                    default:       s = '{level: 1'b1, lead: 17'd2400, trail: 14'd579};
                endcase
            end
            PH_DATA: begin
                case (p)
                    PROTO_RC5:  s = '{level: !b, lead: 17'd880, trail: 14'd871};
                    PROTO_SIRC: s = '{level: 1'b1, lead: b ? 17'd1192 : 17'd587,
                                      trail: 14'd579};
                    default:    s = '{level: 1'b1, lead: 17'd552,
                                      trail: b ? 14'd1668 : 14'd543};
                endcase
            end
            PH_END: s = '{level: 1'b1, lead: 17'd552, trail: 14'd543};
            PH_GAP: begin
                case (p)
                    PROTO_NEC:     s = '{level: 1'b0, lead: 17'd56000, trail: 14'd0};
                    PROTO_SAMSUNG: s = '{level: 1'b0, lead: 17'd44000, trail: 14'd0};
                    PROTO_RC5:     s = '{level: 1'b0, lead: 17'd89000, trail: 14'd0};
                    default:       s = '{level: 1'b0, lead: 17'd27000, trail: 14'd0};
                endcase
            end
            default: s = '{level: 1'b1, lead: 17'd552, trail: 14'd543};
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/irfe_shifter.sv =====
// Data bit shifter of the IR remote frame encoder: hands out one bit per step, LSB first.
// Depends on irfe_pkg.
module irfe_shifter (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  irfe_pkg::sh_ctl_t            ctl,
    input  logic [irfe_pkg::DATA_W-1:0]  load_data,
    input  logic [irfe_pkg::CNT_W-1:0]   load_cnt,
    output logic                         bit_out,
    output logic                         last_bit,
    output logic                         cnt_zero
);

    logic [irfe_pkg::DATA_W-1:0] data_reg, data_next;
    logic [irfe_pkg::CNT_W-1:0]  cnt_reg, cnt_next;

    always_comb begin
        data_next = data_reg;
        cnt_next  = cnt_reg;
        if (ctl.load) begin
            data_next = load_data;
            cnt_next  = load_cnt;
        end else if (ctl.shift) begin
            data_next = data_reg >> 1;
            cnt_next  = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign bit_out  = data_reg[0];
    assign last_bit = (cnt_reg == irfe_pkg::CNT_W'(1));
    assign cnt_zero = (cnt_reg == '0);

endmodule

// ===== rtl/ir_remote_frame_encoder.sv =====
// IR remote frame encoder, top level: request intake, phase sequencer, result register.
// Depends on irfe_pkg, irfe_shifter and ir_remote_frame_encoder_assert.svh.
//
// Usage:
//   One transfer on the s_ channel is one frame request (NEC, Samsung, RC-5
//   or SIRC). The block answers with the frame as a run of segment transfers
//   on the m_ channel: lead level for lead_us, opposite level for trail_us,
//   on carrier_khz. m_tlast marks the final segment of the frame.
//   The request transfer starts the sequencer; it then loads the first segment
//   into the output register once that is free. Throughput: one segment per
//   cycle while m_tready stays high; a frame has 4 to 35 segments, and the
//   next request is taken in the cycle after the last segment is loaded. The
//   single data shifter moves one bit per data-phase segment.
//   s_tready is high only between frames; it may rise while the last
//   segment still waits in the output register.
//   When the receiver stalls, the output register holds its segment and the
//   sequencer waits; nothing is dropped.
//   Reset (aresetn low, synchronous) empties the output register, returns to
//   idle and sets the RC-5 toggle so the first new press sends toggle 0.
`include "ir_remote_frame_encoder_assert.svh"

module ir_remote_frame_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // [15:0] address, [23:16] command
    input  logic [4:0]  s_tuser,  // [1:0] protocol, [3:2] sirc_length, [4] repeat_req
    // segment channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // [0] lead_level, [17:1] lead_us, [31:18] trail_us,
                                  // [37:32] carrier_khz, [39:38] zero
    output logic        m_tlast
);

    // ---- request fields ----
    irfe_pkg::proto_t in_proto;
    logic [15:0]      in_addr;
    logic [7:0]       in_cmd;
    logic [1:0]       in_slen;
    logic             in_rep;

    assign in_addr  = s_tdata[15:0];
    assign in_cmd   = s_tdata[23:16];
    assign in_proto = irfe_pkg::proto_t'(s_tuser[1:0]);
    assign in_slen  = s_tuser[3:2];
    assign in_rep   = s_tuser[4];

    // ---- state ----
    irfe_pkg::state_t             state_reg, state_next;
    irfe_pkg::phase_t             phase_reg, phase_next;
    irfe_pkg::proto_t             proto_reg;
    logic                         rep_reg;
    logic [irfe_pkg::NUM_PH-1:0]  mask_reg;
    logic                         toggle_reg, toggle_next;

    // output register
    logic                            m_valid_reg;
    irfe_pkg::seg_t                  m_seg_reg;
    logic [irfe_pkg::CARRIER_W-1:0]  m_carrier_reg;
    logic                            m_last_reg;

    // ---- control ----
    logic              s_fire;
    logic              out_free;
    logic              emit;
    logic              hold_data;
    logic              nxt_found;
    irfe_pkg::phase_t  nxt_phase;
    logic              seg_last;
    irfe_pkg::seg_t    cur_seg;
    irfe_pkg::sh_ctl_t sh_ctl;

    // shifter
    logic                         sh_bit;
    logic                         sh_last;
    logic                         sh_cnt_zero;
    logic [irfe_pkg::DATA_W-1:0]  load_data;
    logic [irfe_pkg::CNT_W-1:0]   load_cnt;

    // ---- frame setup from the request ----
    logic        toggle_new;
    logic [13:0] rc5_word;
    logic [7:0]  nec_byte2;

    assign toggle_new = toggle_reg ^ !in_rep;
    assign nec_byte2  = (in_addr[15:8] != 8'd0) ? in_addr[15:8] : ~in_addr[7:0];
    assign rc5_word   = {1'b1, !in_cmd[6], toggle_new, in_addr[4:0], in_cmd[5:0]};

    always_comb begin
        load_data = '0;
        load_cnt  = '0;
        case (in_proto)
            irfe_pkg::PROTO_NEC: begin
                load_data = {~in_cmd, in_cmd, nec_byte2, in_addr[7:0]};
                load_cnt  = in_rep ? irfe_pkg::CNT_W'(0) : irfe_pkg::CNT_W'(32);
            end
            irfe_pkg::PROTO_SAMSUNG: begin
                load_data = {~in_cmd, in_cmd, in_addr[7:0], in_addr[7:0]};
                load_cnt  = irfe_pkg::CNT_W'(32);
            end
            irfe_pkg::PROTO_RC5: begin
                // MSB first on air: reverse so the shifter can go LSB first
                for (int i = 0; i < 14; i++) begin
                    load_data[i] = rc5_word[13 - i];
                end
                load_cnt = irfe_pkg::CNT_W'(14);
            end
            default: begin
                // 7 command bits, then 0/5/8/13 address bits
                load_data = {12'd0, in_addr[12:0], in_cmd[6:0]};
                case (in_slen)
                    2'd1:    load_cnt = irfe_pkg::CNT_W'(12);
                    2'd2:    load_cnt = irfe_pkg::CNT_W'(15);
                    2'd3:    load_cnt = irfe_pkg::CNT_W'(20);
                    default: load_cnt = irfe_pkg::CNT_W'(7);
                endcase
            end
        endcase
    end

    // ---- sequencing ----
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign cur_seg  = irfe_pkg::seg_value(proto_reg, rep_reg, phase_reg, sh_bit);

    // stay in the data phase until its final bit goes out
    assign hold_data = (phase_reg == irfe_pkg::PH_DATA) && !sh_last;

    always_comb begin
        nxt_found = 1'b0;
        nxt_phase = phase_reg;
        for (int i = irfe_pkg::NUM_PH - 1; i >= 0; i--) begin
            if (mask_reg[i] && (3'(i) > phase_reg)) begin
                nxt_found = 1'b1;
                nxt_phase = irfe_pkg::phase_t'(3'(i));
            end
        end
    end

    assign seg_last = !hold_data && !nxt_found;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            irfe_pkg::ST_IDLE: if (s_fire) state_next = irfe_pkg::ST_RUN;
            irfe_pkg::ST_RUN:  if (emit && seg_last) state_next = irfe_pkg::ST_IDLE;
            default:           state_next = irfe_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready     = 1'b0;
        emit         = 1'b0;
        sh_ctl.load  = 1'b0;
        sh_ctl.shift = 1'b0;
        unique case (state_reg)
            irfe_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                sh_ctl.load = s_tvalid;
            end
            irfe_pkg::ST_RUN: begin
                emit         = out_free;
                sh_ctl.shift = out_free && (phase_reg == irfe_pkg::PH_DATA);
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        if (s_fire) begin
            phase_next = irfe_pkg::first_phase(irfe_pkg::phase_mask(in_proto, in_rep));
        end else if (emit && !hold_data && nxt_found) begin
            phase_next = nxt_phase;
        end
    end

    always_comb begin
        toggle_next = toggle_reg;
        if (s_fire && (in_proto == irfe_pkg::PROTO_RC5)) begin
            toggle_next = toggle_new;
        end
    end

    irfe_shifter u_shifter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (sh_ctl),
        .load_data (load_data),
        .load_cnt  (load_cnt),
        .bit_out   (sh_bit),
        .last_bit  (sh_last),
        .cnt_zero  (sh_cnt_zero)
    );

    // ---- registers ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= irfe_pkg::ST_IDLE;
            phase_reg   <= irfe_pkg::PH_PRE;
            toggle_reg  <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            toggle_reg <= toggle_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            proto_reg <= in_proto;
            rep_reg   <= in_rep;
            mask_reg  <= irfe_pkg::phase_mask(in_proto, in_rep);
        end
        if (emit) begin
            m_seg_reg     <= cur_seg;
            m_carrier_reg <= irfe_pkg::carrier_of(proto_reg);
            m_last_reg    <= seg_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {2'b00, m_carrier_reg, m_seg_reg.trail, m_seg_reg.lead, m_seg_reg.level};

    // ---- assertions ----
    `IRFE_ASSERT_IMP(a_idle_no_bits, aclk, aresetn,
        state_reg == irfe_pkg::ST_IDLE, sh_cnt_zero, "data bits left over between frames")
    `IRFE_ASSERT_NEXT(a_req_starts_run, aclk, aresetn,
        s_fire, (state_reg == irfe_pkg::ST_RUN) && !s_tready, "request did not start a frame")
    `IRFE_ASSERT_NEXT(a_last_marked, aclk, aresetn,
        emit && seg_last, m_tvalid && m_tlast && (state_reg == irfe_pkg::ST_IDLE),
        "final segment not marked or sequencer still running")
    `IRFE_ASSERT_IMP(a_data_has_bits, aclk, aresetn,
        (state_reg == irfe_pkg::ST_RUN) && (phase_reg == irfe_pkg::PH_DATA), !sh_cnt_zero,
        "data phase with no bits left")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for ir_remote_frame_encoder: frame requests go in on s_, segments
// come back on m_ and are compared field by field with a built-in frame encoder.
// Depends on irfe_pkg and the ir_remote_frame_encoder RTL.
module tb_top;
    import irfe_pkg::*;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int MAX_MSG      = 30;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        proto_t      proto;
        logic [15:0] addr;
        logic [7:0]  cmd;
        logic [1:0]  slen;
        logic        rep;
    } frame_req_t;

    typedef struct {
        logic                 level;
        logic [LEAD_W-1:0]    lead;
        logic [TRAIL_W-1:0]   trail;
        logic [CARRIER_W-1:0] carrier;
        logic                 fin;
    } seg_exp_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;  // [15:0] address, [23:16] command
    logic [4:0]  s_tuser  = '0;  // [1:0] protocol, [3:2] sirc_length, [4] repeat_req
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // [0] level, [17:1] lead_us, [31:18] trail_us,
                                 // [37:32] carrier_khz, [39:38] zero
    logic        m_tlast;

    ir_remote_frame_encoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Expected segments, oldest first, and the encoder's own toggle copy.
    seg_exp_t seg_q[$];
    logic     exp_toggle = 1'b1;

    int err_count    = 0;
    int segs_checked = 0;
    int reqs_sent    = 0;
    int proto_count[4] = '{0, 0, 0, 0};
    int cycle_count  = 0;

    // Sender pacing: bursts of back-to-back requests separated by gaps.
    logic valid_q      = 1'b0;
    logic sender_eager = 1'b0;
    int   burst_left   = 0;
    int   gap_before   = 0;

    // Receiver pacing: a hold-off count set by a test, else a randomly chosen stall pattern.
    int hold_cycles = 0;
    int rx_mode     = 0;
    int rx_mode_left = 0;
    int rx_stall_left = 0;

    // ---------------------------------------------------------------- frame encoder

    function automatic void push_seg(input logic lvl, input logic [LEAD_W-1:0] lead,
                                     input logic [TRAIL_W-1:0] trail,
                                     input logic [CARRIER_W-1:0] ck, input logic fin);
        seg_exp_t s;
        s.level   = lvl;
        s.lead    = lead;
        s.trail   = trail;
        s.carrier = ck;
        s.fin     = fin;
        seg_q.push_back(s);
    endfunction

    // Pulse-distance byte, LSB first (NEC and Samsung).
    function automatic void push_pd_byte(input logic [7:0] v);
        for (int i = 0; i < 8; i++)
            push_seg(1'b1, 17'd552, v[i] ? 14'd1668 : 14'd543, CK_NEC, 1'b0);
    endfunction

    // Pulse-length bits, LSB first (SIRC).
    function automatic void push_pl_bits(input logic [15:0] v, input int count);
        for (int i = 0; i < count; i++)
            push_seg(1'b1, v[i] ? 17'd1192 : 17'd587, 14'd579, CK_SIRC, 1'b0);
    endfunction

    function automatic void encode_frame(input frame_req_t r);
        logic [13:0] rc5_word;
        int          addr_bits;
        case (r.proto)
            PROTO_NEC: begin
                if (r.rep) begin
                    push_seg(1'b0, 17'd40000, 14'd0, CK_NEC, 1'b0);
                    push_seg(1'b1, 17'd9000, 14'd2250, CK_NEC, 1'b0);
                    push_seg(1'b1, 17'd552, 14'd543, CK_NEC, 1'b0);
                    push_seg(1'b0, 17'd56000, 14'd0, CK_NEC, 1'b1);
                end else begin
                    push_seg(1'b1, 17'd9000, 14'd4500, CK_NEC, 1'b0);
                    push_pd_byte(r.addr[7:0]);
                    // extended form carries the high address byte instead of ~addr
                    if (r.addr > 16'd255)
                        push_pd_byte(r.addr[15:8]);
                    else
                        push_pd_byte(~r.addr[7:0]);
                    push_pd_byte(r.cmd);
                    push_pd_byte(~r.cmd);
                    push_seg(1'b1, 17'd552, 14'd543, CK_NEC, 1'b1);
                end
            end
            PROTO_SAMSUNG: begin
                push_seg(1'b1, 17'd4500, 14'd4500, CK_NEC, 1'b0);
                push_pd_byte(r.addr[7:0]);
                push_pd_byte(r.addr[7:0]);
                push_pd_byte(r.cmd);
                push_pd_byte(~r.cmd);
                push_seg(1'b1, 17'd552, 14'd543, CK_NEC, 1'b0);
                push_seg(1'b0, 17'd44000, 14'd0, CK_NEC, 1'b1);
            end
            PROTO_RC5: begin
                if (!r.rep)
                    exp_toggle = ~exp_toggle;
                rc5_word = {1'b1, ~r.cmd[6], exp_toggle, r.addr[4:0], r.cmd[5:0]};
                // bi-phase: a one starts with the carrier off
                for (int i = 13; i >= 0; i--)
                    push_seg(~rc5_word[i], 17'd880, 14'd871, CK_RC5, 1'b0);
                push_seg(1'b0, 17'd89000, 14'd0, CK_RC5, 1'b1);
            end
            default: begin
                case (r.slen)
                    2'd0:    addr_bits = 0;
                    2'd1:    addr_bits = 5;
                    2'd2:    addr_bits = 8;
                    default: addr_bits = 13;
                endcase
                push_seg(1'b1, 17'd2400, 14'd579, CK_SIRC, 1'b0);
                push_pl_bits({8'd0, r.cmd}, 7);
                push_pl_bits(r.addr, addr_bits);
                push_seg(1'b0, 17'd27000, 14'd0, CK_SIRC, 1'b1);
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- request side

    function automatic frame_req_t make_req(input proto_t p, input logic [15:0] a,
                                            input logic [7:0] c, input logic [1:0] sl,
                                            input logic rep);
        frame_req_t r;
        r.proto = p;
        r.addr  = a;
        r.cmd   = c;
        r.slen  = sl;
        r.rep   = rep;
        return r;
    endfunction

    // One request transfer; valid stays up across a burst, drops for a gap.
    task automatic send_frame(input frame_req_t r);
        if (!valid_q)
            repeat (gap_before) @(posedge aclk);
        s_tdata <= {r.cmd, r.addr};
        s_tuser <= {r.rep, r.slen, r.proto};
        if (!valid_q) begin
            s_tvalid <= 1'b1;
            valid_q = 1'b1;
        end
        do @(posedge aclk); while (!s_tready);
        encode_frame(r);
        reqs_sent++;
        proto_count[r.proto]++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            if (sender_eager)
                gap_before = 0;
            else if ($urandom_range(0, 3) == 0)
                gap_before = $urandom_range(1, 40);
            else
                gap_before = $urandom_range(0, 4);
            if (gap_before != 0) begin
                s_tvalid <= 1'b0;
                valid_q = 1'b0;
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic quiesce_input();
        if (valid_q) begin
            s_tvalid <= 1'b0;
            valid_q = 1'b0;
        end
    endtask

    task automatic wait_drained();
        quiesce_input();
        while (seg_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------- receiver

    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            // long hold-off: the output register fills and s_tready stays low
            m_tready <= 1'b0;
            hold_cycles--;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 200);
            end
            rx_mode_left--;
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 7) != 0);
                default: begin
                    if (rx_stall_left > 0) begin
                        m_tready <= 1'b0;
                        rx_stall_left--;
                    end else if ($urandom_range(0, 3) == 0) begin
                        m_tready <= 1'b0;
                        rx_stall_left = $urandom_range(1, 8);
                    end else begin
                        m_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string field, input longint unsigned got,
                                   input longint unsigned want);
        if (err_count < MAX_MSG)
            $display("mismatch at segment %0d: %s got %0d want %0d",
                     segs_checked, field, got, want);
        err_count++;
    endtask

    always @(posedge aclk) begin : seg_check
        seg_exp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (seg_q.size() == 0) begin
                report_mismatch("unexpected transfer, lead_us", m_tdata[17:1], 0);
            end else begin
                want = seg_q.pop_front();
                if (m_tdata[0] !== want.level)
                    report_mismatch("lead_level", m_tdata[0], want.level);
                if (m_tdata[17:1] !== want.lead)
                    report_mismatch("lead_us", m_tdata[17:1], want.lead);
                if (m_tdata[31:18] !== want.trail)
                    report_mismatch("trail_us", m_tdata[31:18], want.trail);
                if (m_tdata[37:32] !== want.carrier)
                    report_mismatch("carrier_khz", m_tdata[37:32], want.carrier);
                if (m_tdata[39:38] !== 2'b00)
                    report_mismatch("tdata pad", m_tdata[39:38], 0);
                if (m_tlast !== want.fin)
                    report_mismatch("tlast", m_tlast, want.fin);
            end
            segs_checked++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d segments outstanding",
                     cycle_count, seg_q.size());
            $display("tb_top: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_nec_frames();
        send_frame(make_req(PROTO_NEC, 16'h0000, 8'h00, 2'd0, 1'b0));
        send_frame(make_req(PROTO_NEC, 16'h00FF, 8'hFF, 2'd3, 1'b0));
        // first address that switches to the extended form
        send_frame(make_req(PROTO_NEC, 16'h0100, 8'h5A, 2'd1, 1'b0));
        send_frame(make_req(PROTO_NEC, 16'hFFFF, 8'hA5, 2'd2, 1'b0));
        send_frame(make_req(PROTO_NEC, 16'hFFFF, 8'hFF, 2'd3, 1'b1));
        wait_drained();
    endtask

    task automatic test_samsung_frames();
        send_frame(make_req(PROTO_SAMSUNG, 16'hFFFF, 8'h00, 2'd0, 1'b0));
        send_frame(make_req(PROTO_SAMSUNG, 16'h0000, 8'hFF, 2'd3, 1'b0));
        send_frame(make_req(PROTO_SAMSUNG, 16'h1234, 8'h81, 2'd2, 1'b1));
        wait_drained();
    endtask

    // Repeat before any press sends the reset toggle; later presses flip it.
    task automatic test_rc5_toggle();
        send_frame(make_req(PROTO_RC5, 16'hFFFF, 8'hFF, 2'd3, 1'b1));
        send_frame(make_req(PROTO_RC5, 16'h001F, 8'h3F, 2'd0, 1'b0));
        send_frame(make_req(PROTO_RC5, 16'hFFE0, 8'h40, 2'd1, 1'b0));
        send_frame(make_req(PROTO_RC5, 16'h0015, 8'h2A, 2'd2, 1'b1));
        send_frame(make_req(PROTO_RC5, 16'h000A, 8'h80, 2'd0, 1'b0));
        wait_drained();
    endtask

    task automatic test_sirc_lengths();
        for (int sl = 0; sl < 4; sl++)
            send_frame(make_req(PROTO_SIRC, 16'hFFFF, 8'hFF, 2'(sl), 1'b0));
        send_frame(make_req(PROTO_SIRC, 16'h0000, 8'h00, 2'd3, 1'b1));
        send_frame(make_req(PROTO_SIRC, 16'h1555, 8'h2A, 2'd2, 1'b0));
        wait_drained();
    endtask

    task automatic test_backpressure();
        sender_eager = 1'b1;
        hold_cycles  = 400;
        send_frame(make_req(PROTO_SAMSUNG, 16'h00C3, 8'h3C, 2'd0, 1'b0));
        send_frame(make_req(PROTO_NEC, 16'hBEEF, 8'h12, 2'd0, 1'b0));
        send_frame(make_req(PROTO_RC5, 16'h0011, 8'h55, 2'd0, 1'b0));
        send_frame(make_req(PROTO_SIRC, 16'h1ABC, 8'h7E, 2'd3, 1'b0));
        send_frame(make_req(PROTO_NEC, 16'h0000, 8'h00, 2'd0, 1'b1));
        send_frame(make_req(PROTO_RC5, 16'h0003, 8'h01, 2'd0, 1'b1));
        sender_eager = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_frames(input int count);
        frame_req_t r;
        for (int k = 0; k < count; k++) begin
            // a stretch with no sender gaps in the middle of the run
            sender_eager = (k >= count / 3) && (k < count / 2);
            r.proto = proto_t'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0:       r.addr = 16'($urandom_range(0, 255));
                1:       r.addr = 16'($urandom_range(256, 65535));
                default: r.addr = 16'($urandom);
            endcase
            r.cmd  = 8'($urandom);
            r.slen = 2'($urandom_range(0, 3));
            r.rep  = ($urandom_range(0, 3) == 0);
            send_frame(r);
        end
        sender_eager = 1'b0;
        wait_drained();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_rc5_toggle();
        test_nec_frames();
        test_samsung_frames();
        test_sirc_lengths();
        test_backpressure();
        test_random_frames(195);

        $display("summary: %0d requests (NEC %0d, Samsung %0d, RC-5 %0d, SIRC %0d)",
                 reqs_sent, proto_count[0], proto_count[1], proto_count[2], proto_count[3]);
        $display("summary: %0d segments compared, %0d mismatches, %0d cycles",
                 segs_checked, err_count, cycle_count);
        if (err_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
